/* design/nbody_velocity_verlet_step_core_defines.svh */
// ----------------------------------------------------------------------------
// nbody velocity verlet step core: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NBODY_VELOCITY_VERLET_STEP_CORE_DEFINES_SVH
`define NBODY_VELOCITY_VERLET_STEP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define NBVV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define NBVV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define NBVV_ASSERT(lbl, prop, msg)
`define NBVV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/nbvv_pkg.sv */
// ----------------------------------------------------------------------------
// nbvv_pkg
// Shared constants, beat types and saturating helpers for the n-body core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbvv_pkg;

    localparam int NUM_BODIES = 4;
    localparam int IDX_W      = $clog2(NUM_BODIES);
    localparam int CNT_W      = $clog2(NUM_BODIES + 1);

    // configuration register indexes
    localparam logic [0:0] CFG_TIME_STEP     = 1'd0;
    localparam logic [0:0] CFG_ACTIVE_BODIES = 1'd1;

    localparam logic [9:0] TIME_STEP_RST     = 10'd10;
    localparam logic [2:0] ACTIVE_BODIES_RST = 3'd3;

    localparam logic [0:0] OPER_LOAD = 1'b0;

    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINNEG = 64'h8000_0000_0000_0000;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_SQRT
    } t_uop;

    typedef struct packed {
        logic start;
        t_uop op;
    } t_ureq;

    typedef struct packed {
        logic               operation;
        logic        [1:0]  body_index;
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic        [62:0] grav_param;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  out_index;
        logic signed [63:0] out_pos_x;
        logic signed [63:0] out_pos_y;
        logic signed [63:0] out_vel_x;
        logic signed [63:0] out_vel_y;
        logic               last;
    } t_out_item;

    // signed 64-bit add that sticks at the range ends
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? MINNEG : MAXPOS;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag_of(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

/* design/nbvv_arith_unit.sv */
// ----------------------------------------------------------------------------
// nbvv_arith_unit
// Bit-serial multiply (128x64), restoring divide (128/128) and integer square
// root (128 -> 64), one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbvv_arith_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nbvv_pkg::t_ureq       i_req,
    input  logic [127:0]          i_a,
    input  logic [127:0]          i_b,
    output logic                  o_done,
    output logic [191:0]          o_res
);
    import nbvv_pkg::*;

    logic [191:0] r_acc;
    logic [191:0] r_x;
    logic [127:0] r_y;
    logic [6:0]   r_cnt;
    logic         r_run;
    logic         r_done;
    t_uop         r_op;

    logic [128:0] w_drem;
    logic         w_dge;
    logic [67:0]  w_srem;
    logic [67:0]  w_strial;
    logic         w_sge;
    logic         w_last;

    // divide step: shift in next numerator bit, trial subtract
    assign w_drem   = {r_acc[127:0], r_x[127]};
    assign w_dge    = w_drem >= {1'b0, r_y};
    // root step: bring down two bits, trial subtract 4*root+1
    assign w_srem   = {r_acc[65:0], r_x[127:126]};
    assign w_strial = {2'b00, r_y[63:0], 2'b01};
    assign w_sge    = w_srem >= w_strial;
    assign w_last   = (r_op == UOP_DIV) ? (r_cnt == 7'd127) : (r_cnt == 7'd63);

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= UOP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_op  <= i_req.op;
                r_cnt <= '0;
                r_acc <= '0;
                r_x   <= {64'd0, i_a};
                r_y   <= (i_req.op == UOP_SQRT) ? 128'd0 : i_b;
            end else if (r_run) begin
                case (r_op)
                    UOP_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[190:0], 1'b0};
                        r_y <= {1'b0, r_y[127:1]};
                    end
                    UOP_DIV: begin
                        if (w_dge) begin
                            r_acc <= {63'd0, w_drem - {1'b0, r_y}};
                        end else begin
                            r_acc <= {63'd0, w_drem};
                        end
                        r_x <= {64'd0, r_x[126:0], w_dge};
                    end
                    UOP_SQRT: begin
                        if (w_sge) begin
                            r_acc <= {124'd0, w_srem - w_strial};
                        end else begin
                            r_acc <= {124'd0, w_srem};
                        end
                        r_x <= {r_x[189:0], 2'b00};
                        r_y <= {r_y[126:0], w_sge};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt + 7'd1;
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

    // result selection
    always_comb begin
        case (r_op)
            UOP_MUL:  o_res = r_acc;
            UOP_DIV:  o_res = {64'd0, r_x[127:0]};
            UOP_SQRT: o_res = {128'd0, r_y[63:0]};
            default:  o_res = r_acc;
        endcase
    end

endmodule

/* design/nbody_velocity_verlet_step_core.sv */
// ----------------------------------------------------------------------------
// nbody_velocity_verlet_step_core
// Planar n-body gravity, one velocity-Verlet step per step beat.
// ----------------------------------------------------------------------------
// A load beat writes one body. A step beat runs every ordered pair of active
// bodies twice through one shared bit-serial unit. Each unit operation runs
// from a start request through its iterations to a done. One pair takes a
// setup state, two squares, a root, three divides and two multiplies (only
// the two squares for a coincident pair); each kick or drift term is one
// multiply plus a dispatch state. Input stall stays high from the step beat
// until the last result beat has been loaded into the output register.
`timescale 1ns / 1ps
`include "nbody_velocity_verlet_step_core_defines.svh"

module nbody_velocity_verlet_step_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  nbvv_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output nbvv_pkg::t_out_item   o_item,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_addr,
    input  logic [9:0]            i_cfg_data
);
    import nbvv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_I,
        S_PAIR,
        S_MSQ,
        S_SQRT,
        S_DIVF,
        S_DIVC,
        S_MULF,
        S_UPD,
        S_USC,
        S_OUT
    } t_state;

    t_state r_state;

    // body state
    logic [63:0] r_pos_x [NUM_BODIES];
    logic [63:0] r_pos_y [NUM_BODIES];
    logic [63:0] r_vel_x [NUM_BODIES];
    logic [63:0] r_vel_y [NUM_BODIES];
    logic [62:0] r_grav  [NUM_BODIES];
    logic [63:0] r_axs   [NUM_BODIES];
    logic [63:0] r_ays   [NUM_BODIES];

    logic [9:0]       r_time_step;
    logic [2:0]       r_active;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_j;
    logic             r_phase;
    logic [1:0]       r_sub;
    logic             r_axis;
    logic             r_issued;

    // pair working registers
    logic [63:0]  r_pix;
    logic [63:0]  r_piy;
    logic [47:0]  r_ux;
    logic [47:0]  r_uy;
    logic         r_nx;
    logic         r_ny;
    logic [62:0]  r_g;
    logic [127:0] r_r2;
    logic [63:0]  r_r;
    logic [127:0] r_f;
    logic [32:0]  r_c;
    logic [63:0]  r_axa;
    logic [63:0]  r_aya;

    logic      r_ov;
    t_out_item r_oitem;

    logic [IDX_W-1:0] w_rd;
    logic [63:0]      w_bpx;
    logic [63:0]      w_bpy;
    logic             w_dxn;
    logic             w_dyn;
    logic [63:0]      w_dxm;
    logic [63:0]      w_dym;
    logic [47:0]      w_u;
    logic             w_unit_st;
    t_ureq            w_req;
    logic [127:0]     w_a;
    logic [127:0]     w_b;
    logic             w_u_done;
    logic [191:0]     w_u_res;
    logic [63:0]      w_m;
    logic [63:0]      w_macc;
    logic [127:0]     w_r2sum;
    logic [63:0]      w_uv;
    logic [63:0]      w_tgt;
    logic [191:0]     w_q;
    logic [63:0]      w_sm;
    logic [63:0]      w_new;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_oload;
    logic             w_sub_last;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_ov && !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_ov;
    assign o_item    = r_oitem;

    // next result beat goes into the output register
    assign w_oload = (r_state == S_OUT) && (r_k != r_n) && (!r_ov || w_out_acc);

    // single body read port: partner during pair setup, else the current body
    assign w_rd  = (r_state == S_PAIR) ? r_j[IDX_W-1:0] : r_k[IDX_W-1:0];
    assign w_bpx = r_pos_x[w_rd];
    assign w_bpy = r_pos_y[w_rd];

    // exact separation magnitudes and signs
    assign w_dxn = $signed(w_bpx) < $signed(r_pix);
    assign w_dyn = $signed(w_bpy) < $signed(r_piy);
    assign w_dxm = w_dxn ? (r_pix - w_bpx) : (w_bpx - r_pix);
    assign w_dym = w_dyn ? (r_piy - w_bpy) : (w_bpy - r_piy);

    assign w_u = r_axis ? r_uy : r_ux;

    // shared unit request and operands
    assign w_unit_st = r_state inside {S_MSQ, S_SQRT, S_DIVF, S_DIVC, S_MULF, S_USC};

    always_comb begin
        w_a = '0;
        w_b = '0;
        w_req.start = w_unit_st && !r_issued;
        w_req.op = UOP_MUL;
        case (r_state)
            S_MSQ: begin
                w_a = {80'd0, w_u};
                w_b = {80'd0, w_u};
            end
            S_SQRT: begin
                w_req.op = UOP_SQRT;
                w_a = r_r2;
            end
            S_DIVF: begin
                w_req.op = UOP_DIV;
                w_a = {1'b0, r_g, 64'd0};
                w_b = r_r2;
            end
            S_DIVC: begin
                w_req.op = UOP_DIV;
                w_a = {48'd0, w_u, 32'd0};
                w_b = {64'd0, r_r};
            end
            S_MULF: begin
                w_a = r_f;
                w_b = {95'd0, r_c};
            end
            S_USC: begin
                w_a = {64'd0, mag_of(w_uv)};
                w_b = {118'd0, r_time_step};
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    nbvv_arith_unit u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_u_done),
        .o_res   (w_u_res)
    );

    // per-axis force magnitude, capped
    always_comb begin
        if (r_f[127:96] != 32'd0) begin
            w_m = (r_c != 33'd0) ? MAXPOS : 64'd0;
        end else if (w_u_res[191:95] != 97'd0) begin
            w_m = MAXPOS;
        end else begin
            w_m = w_u_res[95:32];
        end
    end

    assign w_macc  = sat_add(r_axis ? r_aya : r_axa,
                             (r_axis ? r_ny : r_nx) ? (64'd0 - w_m) : w_m);
    assign w_r2sum = r_r2 + w_u_res[127:0];

    // kick and drift operand and target
    always_comb begin
        case (r_sub)
            2'd0: begin
                w_uv  = r_axs[w_rd];
                w_tgt = r_vel_x[w_rd];
            end
            2'd1: begin
                w_uv  = r_ays[w_rd];
                w_tgt = r_vel_y[w_rd];
            end
            2'd2: begin
                w_uv  = r_vel_x[w_rd];
                w_tgt = r_pos_x[w_rd];
            end
            default: begin
                w_uv  = r_vel_y[w_rd];
                w_tgt = r_pos_y[w_rd];
            end
        endcase
    end

    assign w_q        = r_sub[1] ? (w_u_res >> 16) : (w_u_res >> 1);
    assign w_sm       = (w_q[191:63] != 129'd0) ? MAXPOS : {1'b0, w_q[62:0]};
    assign w_new      = sat_add(w_tgt, w_uv[63] ? (64'd0 - w_sm) : w_sm);
    assign w_sub_last = r_phase ? (r_sub == 2'd1) : (r_sub == 2'd3);

    // sequencer, body state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_step <= TIME_STEP_RST;
            r_active    <= ACTIVE_BODIES_RST;
            r_n         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_phase     <= 1'b0;
            r_sub       <= '0;
            r_axis      <= 1'b0;
            r_issued    <= 1'b0;
            r_ov        <= 1'b0;
            for (int b = 0; b < NUM_BODIES; b++) begin
                r_pos_x[b] <= '0;
                r_pos_y[b] <= '0;
                r_vel_x[b] <= '0;
                r_vel_y[b] <= '0;
                r_grav[b]  <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TIME_STEP:     r_time_step <= i_cfg_data;
                    CFG_ACTIVE_BODIES: r_active    <= i_cfg_data[2:0];
                    default:           r_time_step <= r_time_step;
                endcase
            end

            // output valid: set on load, cleared on accept
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (w_out_acc) begin
                r_ov <= 1'b0;
            end

            if (w_unit_st) begin
                if (!r_issued) begin
                    r_issued <= 1'b1;
                end else if (w_u_done) begin
                    r_issued <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_item.operation == OPER_LOAD) begin
                            if (int'(i_item.body_index) < NUM_BODIES) begin
                                r_pos_x[IDX_W'(i_item.body_index)] <= i_item.pos_x;
                                r_pos_y[IDX_W'(i_item.body_index)] <= i_item.pos_y;
                                r_vel_x[IDX_W'(i_item.body_index)] <= i_item.vel_x;
                                r_vel_y[IDX_W'(i_item.body_index)] <= i_item.vel_y;
                                r_grav[IDX_W'(i_item.body_index)]  <= i_item.grav_param;
                            end
                        end else begin
                            if (int'(r_active) > NUM_BODIES) begin
                                r_n <= CNT_W'(NUM_BODIES);
                            end else begin
                                r_n <= CNT_W'(r_active);
                            end
                            r_k     <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_ACC_I;
                        end
                    end
                end
                S_ACC_I: begin
                    if (r_k == r_n) begin
                        r_k     <= '0;
                        r_sub   <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_pix   <= w_bpx;
                        r_piy   <= w_bpy;
                        r_axa   <= '0;
                        r_aya   <= '0;
                        r_j     <= '0;
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    if (r_j == r_n) begin
                        r_axs[r_k[IDX_W-1:0]] <= r_axa;
                        r_ays[r_k[IDX_W-1:0]] <= r_aya;
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_ACC_I;
                    end else if (r_j == r_k) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_ux    <= w_dxm[63:16];
                        r_uy    <= w_dym[63:16];
                        r_nx    <= w_dxn;
                        r_ny    <= w_dyn;
                        r_g     <= r_grav[w_rd];
                        r_axis  <= 1'b0;
                        r_state <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    if (w_u_done) begin
                        if (!r_axis) begin
                            r_r2   <= w_u_res[127:0];
                            r_axis <= 1'b1;
                        end else if (w_r2sum == 128'd0) begin
                            // coincident pair: no force
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_PAIR;
                        end else begin
                            r_r2    <= w_r2sum;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (w_u_done) begin
                        r_r     <= w_u_res[63:0];
                        r_state <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    if (w_u_done) begin
                        r_f     <= w_u_res[127:0];
                        r_axis  <= 1'b0;
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (w_u_done) begin
                        r_c     <= w_u_res[32:0];
                        r_state <= S_MULF;
                    end
                end
                S_MULF: begin
                    if (w_u_done) begin
                        if (!r_axis) begin
                            r_axa   <= w_macc;
                            r_axis  <= 1'b1;
                            r_state <= S_DIVC;
                        end else begin
                            r_aya   <= w_macc;
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_PAIR;
                        end
                    end
                end
                S_UPD: begin
                    if (r_k == r_n) begin
                        r_k <= '0;
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_ACC_I;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_USC;
                    end
                end
                S_USC: begin
                    if (w_u_done) begin
                        case (r_sub)
                            2'd0:    r_vel_x[w_rd] <= w_new;
                            2'd1:    r_vel_y[w_rd] <= w_new;
                            2'd2:    r_pos_x[w_rd] <= w_new;
                            default: r_pos_y[w_rd] <= w_new;
                        endcase
                        if (w_sub_last) begin
                            r_sub <= '0;
                            r_k   <= r_k + CNT_W'(1);
                        end else begin
                            r_sub <= r_sub + 2'd1;
                        end
                        r_state <= S_UPD;
                    end
                end
                S_OUT: begin
                    if (r_k == r_n) begin
                        r_state <= S_IDLE;
                    end else if (w_oload) begin
                        r_oitem.out_index <= r_k[1:0];
                        r_oitem.out_pos_x <= r_pos_x[w_rd];
                        r_oitem.out_pos_y <= r_pos_y[w_rd];
                        r_oitem.out_vel_x <= r_vel_x[w_rd];
                        r_oitem.out_vel_y <= r_vel_y[w_rd];
                        r_oitem.last      <= (r_k + CNT_W'(1) == r_n);
                        r_k               <= r_k + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `NBVV_ASSERT(a_ov_from_out, $rose(r_ov) |-> $past(r_state == S_OUT), "beat outside output")
    `NBVV_ASSERT(a_unit_no_early_done, w_req.start |=> !w_u_done, "unit done after start")
    `NBVV_ASSERT_ALWAYS(a_idle_no_issue, (i_rst_n && r_state == S_IDLE) |-> !r_issued, "idle req")

endmodule
